[src/scc_pkg.sv]
// Shared types, codes and constants of the snoop coherence controller.
`timescale 1ns / 1ps

package scc_pkg;

    // Default geometry of the state store.
    localparam int DEF_NUM_CACHES     = 4;
    localparam int DEF_LINE_ADDR_BITS = 10;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Item kinds as they arrive.
    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_SNOOP  = 2'd1,
        ACT_REPLY  = 2'd2
    } t_action;

    // Snooped request kinds.
    typedef enum logic [1:0] {
        SN_READ    = 2'd0,
        SN_WRITE   = 2'd1,
        SN_UPGRADE = 2'd2
    } t_snoop;

    // Bus reply kinds.
    typedef enum logic [1:0] {
        RP_CACHE  = 2'd0,
        RP_MEMORY = 2'd1,
        RP_SHARED = 2'd2
    } t_reply;

    // Bus request issued on a lookup miss.
    typedef enum logic [1:0] {
        BUS_NONE    = 2'd0,
        BUS_READ    = 2'd1,
        BUS_WRITE   = 2'd2,
        BUS_UPGRADE = 2'd3
    } t_bus;

    // Answer to a snooped request.
    typedef enum logic [1:0] {
        ANS_NONE   = 2'd0,
        ANS_SHARED = 2'd1,
        ANS_DATA   = 2'd2
    } t_answer;

    // Coherence state of one line.
    typedef enum logic [2:0] {
        ST_I = 3'd0,
        ST_S = 3'd1,
        ST_E = 3'd2,
        ST_O = 3'd3,
        ST_M = 3'd4,
        ST_F = 3'd5
    } t_line;

    // Protocol selection.
    typedef enum logic [2:0] {
        PROTO_MI    = 3'd0,
        PROTO_MSI   = 3'd1,
        PROTO_MESI  = 3'd2,
        PROTO_MOESI = 3'd3,
        PROTO_MESIF = 3'd4
    } t_proto;

    // Operation decided by the front part.
    typedef enum logic [2:0] {
        OP_LOOKUP = 3'd0,
        OP_SNOOP  = 3'd1,
        OP_REPLY  = 3'd2,
        OP_PEEK   = 3'd3,
        OP_DROP   = 3'd4
    } t_op;

    // Sequencer states of the back part.
    typedef enum logic [1:0] {
        BK_CLEAR = 2'd0,
        BK_IDLE  = 2'd1,
        BK_EXEC  = 2'd2
    } t_back_state;

    // Input word.
    typedef struct packed {
        logic [1:0] action;
        logic [1:0] cache_id;
        logic [9:0] line_address;
        logic       is_store;
        logic [1:0] snoop_kind;
        logic [1:0] reply_kind;
        logic [1:0] requester;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic       hit;
        logic [1:0] bus_request;
        logic [1:0] snoop_answer;
        logic [1:0] answer_dest;
        logic       cpu_done;
        logic [2:0] line_state;
        logic       protocol_error;
    } t_out_word;

    // Classified command held in the queue.
    typedef struct packed {
        t_op        op;
        logic       is_store;
        logic [1:0] snoop_kind;
        logic [1:0] reply_kind;
        logic [1:0] requester;
    } t_cmd;

    // Status from the back part to the front part.
    typedef struct packed {
        logic clear_done;
    } t_back_status;

endpackage

[src/snoop_coherence_controller_top.sv]
// Top level of the snoop coherence controller: protocol register, front and back parts.
`timescale 1ns / 1ps

// Each word reads one line state from the state store, works out the new state
// and the answers, and writes the line back. The back part handles one word at a
// time: its idle state pops the word and reads the store, and its execute state
// updates the store and loads the result register, waiting there while the result
// register holds a word not yet taken; the front queue of two words lets input keep
// arriving while a result waits to be taken. After reset the state store is
// cleared one line per cycle; no input word is taken until that pass is over,
// while protocol writes are taken at once.
// The protocol register may only be written while no word is in flight.
module snoop_coherence_controller_top
    import scc_pkg::*;
#(
    parameter int NUM_CACHES     = DEF_NUM_CACHES,
    parameter int LINE_ADDR_BITS = DEF_LINE_ADDR_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in_word,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out_word,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [2:0] i_cfg_data
);

    localparam int IDX_W = $clog2(NUM_CACHES) + LINE_ADDR_BITS;

    logic [2:0]       r_protocol;
    t_back_status     w_status;
    logic             w_q_valid;
    t_cmd             w_q_cmd;
    logic [IDX_W-1:0] w_q_idx;
    logic             w_pop;

    // Protocol register; always ready for a write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protocol <= PROTO_MI;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_protocol <= i_cfg_data;
        end
    end

    scc_front #(
        .NUM_CACHES     (NUM_CACHES),
        .LINE_ADDR_BITS (LINE_ADDR_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .i_status   (w_status),
        .o_q_valid  (w_q_valid),
        .o_q_cmd    (w_q_cmd),
        .o_q_idx    (w_q_idx),
        .i_q_pop    (w_pop)
    );

    scc_back #(
        .NUM_CACHES     (NUM_CACHES),
        .LINE_ADDR_BITS (LINE_ADDR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_protocol  (r_protocol),
        .i_q_valid   (w_q_valid),
        .i_q_cmd     (w_q_cmd),
        .i_q_idx     (w_q_idx),
        .o_q_pop     (w_pop),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // The back part never pops an empty queue.
    a_pop_needs_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("queue popped while empty");

    // Nothing leaves the queue while the state store is being cleared.
    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_status.clear_done |-> !w_pop)
        else $error("queue popped during clearing pass");

    // A completed processor request always leaves a valid line.
    a_done_valid_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.cpu_done) |-> (o_out_word.line_state != ST_I))
        else $error("request completed on an invalid line");

    // A bus request is only issued on a miss.
    a_bus_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.bus_request != BUS_NONE))
            |-> (!o_out_word.hit && !o_out_word.cpu_done))
        else $error("bus request issued with a hit");

endmodule

[src/scc_front.sv]
// Front part: accepts input words, classifies them and queues them for the back part.
`timescale 1ns / 1ps

module scc_front
    import scc_pkg::*;
#(
    parameter int NUM_CACHES     = DEF_NUM_CACHES,
    parameter int LINE_ADDR_BITS = DEF_LINE_ADDR_BITS,
    localparam int IDX_W         = $clog2(NUM_CACHES) + LINE_ADDR_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_word           i_in_word,
    input  t_back_status       i_status,
    output logic               o_q_valid,
    output t_cmd               o_q_cmd,
    output logic [IDX_W-1:0]   o_q_idx,
    input  logic               i_q_pop
);

    localparam logic [IDX_W-1:0] ADDR_MASK = IDX_W'((1 << LINE_ADDR_BITS) - 1);

    logic               w_push;
    logic               w_in_range;
    t_cmd               w_cmd;
    logic [IDX_W-1:0]   w_idx;

    t_cmd               r_q_cmd [QUEUE_DEPTH];
    logic [IDX_W-1:0]   r_q_idx [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic [QPTR_W-1:0]  n_wr_ptr;
    logic [QPTR_W-1:0]  n_rd_ptr;
    logic [QCNT_W-1:0]  n_count;

    // Words are taken once the state store is cleared and the queue has room.
    assign o_in_ready = i_status.clear_done && (r_count != QCNT_W'(QUEUE_DEPTH));
    assign w_push     = i_in_valid && o_in_ready;

    // Flat index of the line in the state store.
    assign w_in_range = int'(i_in_word.cache_id) < NUM_CACHES;
    assign w_idx      = (IDX_W'(i_in_word.cache_id) << LINE_ADDR_BITS)
                      | (IDX_W'(i_in_word.line_address) & ADDR_MASK);

    // Classify the word; unknown codes only report the current state.
    always_comb begin
        w_cmd.is_store   = i_in_word.is_store;
        w_cmd.snoop_kind = i_in_word.snoop_kind;
        w_cmd.reply_kind = i_in_word.reply_kind;
        w_cmd.requester  = i_in_word.requester;
        case (i_in_word.action)
            ACT_LOOKUP: begin
                w_cmd.op = OP_LOOKUP;
            end
            ACT_SNOOP: begin
                w_cmd.op = (i_in_word.snoop_kind inside {SN_READ, SN_WRITE, SN_UPGRADE})
                         ? OP_SNOOP : OP_PEEK;
            end
            ACT_REPLY: begin
                w_cmd.op = (i_in_word.reply_kind inside {RP_CACHE, RP_MEMORY, RP_SHARED})
                         ? OP_REPLY : OP_PEEK;
            end
            default: begin
                w_cmd.op = OP_PEEK;
            end
        endcase
        if (!w_in_range) begin
            w_cmd.op = OP_DROP;
        end
    end

    // Queue pointer and fill count updates.
    always_comb begin
        n_wr_ptr = w_push  ? r_wr_ptr + QPTR_W'(1) : r_wr_ptr;
        n_rd_ptr = i_q_pop ? r_rd_ptr + QPTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !i_q_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!w_push && i_q_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_cmd[r_wr_ptr] <= w_cmd;
            r_q_idx[r_wr_ptr] <= w_idx;
        end
    end

    assign o_q_valid = r_count != '0;
    assign o_q_cmd   = r_q_cmd[r_rd_ptr];
    assign o_q_idx   = r_q_idx[r_rd_ptr];

endmodule

[src/scc_back.sv]
// Back part: state store, read-modify-write sequencer and result register.
`timescale 1ns / 1ps

module scc_back
    import scc_pkg::*;
#(
    parameter int NUM_CACHES     = DEF_NUM_CACHES,
    parameter int LINE_ADDR_BITS = DEF_LINE_ADDR_BITS,
    localparam int IDX_W         = $clog2(NUM_CACHES) + LINE_ADDR_BITS,
    localparam int MEM_DEPTH     = 1 << IDX_W
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [2:0]         i_protocol,
    input  logic               i_q_valid,
    input  t_cmd               i_q_cmd,
    input  logic [IDX_W-1:0]   i_q_idx,
    output logic               o_q_pop,
    output t_back_status       o_status,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_word          o_out_word
);

    t_back_state        r_state;
    t_back_state        n_state;
    logic [IDX_W-1:0]   r_clr_idx;
    t_cmd               r_cmd;
    logic [IDX_W-1:0]   r_idx;
    logic [2:0]         r_rd_data;
    logic [2:0]         r_mem [MEM_DEPTH];
    logic               r_out_valid;
    t_out_word          r_out_word;

    logic               w_out_free;
    logic               w_mem_re;
    logic               w_mem_we;
    logic [IDX_W-1:0]   w_mem_wa;
    logic [2:0]         w_mem_wd;
    logic               w_out_load;
    logic               w_clr_step;
    t_proto             w_proto;
    t_line              w_s;
    t_line              w_ns;
    t_out_word          w_res;
    logic               w_hit;
    t_bus               w_bus;
    t_answer            w_ans;
    logic               w_done;
    logic               w_err;

    assign w_out_free          = !r_out_valid || i_out_ready;
    assign o_status.clear_done = r_state != BK_CLEAR;

    // Protocol values above MESIF behave as MI.
    assign w_proto = (i_protocol > PROTO_MESIF) ? PROTO_MI : t_proto'(i_protocol);
    assign w_s     = t_line'(r_rd_data);

    // Next coherence state and answers for the command under execution.
    always_comb begin
        w_hit  = 1'b0;
        w_bus  = BUS_NONE;
        w_ans  = ANS_NONE;
        w_done = 1'b0;
        w_err  = 1'b0;
        w_ns   = w_s;
        case (r_cmd.op)
            OP_LOOKUP: begin
                if (!r_cmd.is_store) begin
                    case (w_proto)
                        PROTO_MSI:   w_hit = (w_s == ST_M) || (w_s == ST_S);
                        PROTO_MESI:  w_hit = (w_s inside {ST_M, ST_E, ST_S});
                        PROTO_MOESI: w_hit = (w_s inside {ST_M, ST_O, ST_E, ST_S});
                        PROTO_MESIF: w_hit = (w_s inside {ST_M, ST_E, ST_S, ST_F});
                        default:     w_hit = (w_s == ST_M);
                    endcase
                end else if (w_s == ST_M) begin
                    w_hit = 1'b1;
                end else if ((w_s == ST_E) && (w_proto != PROTO_MI)
                             && (w_proto != PROTO_MSI)) begin
                    w_hit = 1'b1;
                    w_ns  = ST_M;
                end
                if (w_hit) begin
                    w_done = 1'b1;
                end else if (r_cmd.is_store && (w_s == ST_S)
                             && ((w_proto == PROTO_MSI) || (w_proto == PROTO_MESI))) begin
                    w_bus = BUS_UPGRADE;
                end else begin
                    w_bus = r_cmd.is_store ? BUS_WRITE : BUS_READ;
                end
            end
            OP_SNOOP: begin
                // An invalid line neither moves nor answers.
                if (w_s != ST_I) begin
                    case (r_cmd.snoop_kind)
                        SN_READ: begin
                            case (w_proto)
                                PROTO_MSI, PROTO_MESI: begin
                                    w_ns  = ST_S;
                                    w_ans = ANS_SHARED;
                                end
                                PROTO_MOESI: begin
                                    if ((w_s == ST_S) || (w_s == ST_F)) begin
                                        w_ns = ST_S;
                                    end else begin
                                        w_ns  = ST_O;
                                        w_ans = ANS_SHARED;
                                    end
                                end
                                PROTO_MESIF: begin
                                    w_ns = ST_S;
                                    if (w_s != ST_S) begin
                                        w_ans = ANS_SHARED;
                                    end
                                end
                                default: begin
                                    w_ns = ST_I;
                                    if (w_s == ST_M) begin
                                        w_ans = ANS_DATA;
                                    end
                                end
                            endcase
                        end
                        SN_WRITE: begin
                            w_ns = ST_I;
                            if (w_proto == PROTO_MI) begin
                                w_ans = (w_s == ST_M) ? ANS_DATA : ANS_NONE;
                            end else if (w_proto == PROTO_MESIF) begin
                                w_ans = (w_s == ST_S) ? ANS_NONE : ANS_DATA;
                            end else begin
                                w_ans = ANS_DATA;
                            end
                        end
                        SN_UPGRADE: begin
                            if ((w_s == ST_M) || (w_s == ST_E)) begin
                                w_err = 1'b1;
                            end else begin
                                w_ns = ST_I;
                            end
                        end
                        default: begin
                            w_ns = w_s;
                        end
                    endcase
                end
            end
            OP_REPLY: begin
                if (r_cmd.is_store || (w_proto == PROTO_MI)) begin
                    w_ns = ST_M;
                end else if (r_cmd.reply_kind == RP_SHARED) begin
                    w_ns = (w_proto == PROTO_MESIF) ? ST_F : ST_S;
                end else begin
                    w_ns = (w_proto == PROTO_MSI) ? ST_M : ST_E;
                end
                w_done = 1'b1;
            end
            default: begin
                w_ns = w_s;
            end
        endcase
    end

    // Result word; an out-of-range cache reports all zero.
    always_comb begin
        w_res                = '0;
        w_res.hit            = w_hit;
        w_res.bus_request    = w_bus;
        w_res.snoop_answer   = w_ans;
        w_res.answer_dest    = (w_ans != ANS_NONE) ? r_cmd.requester : 2'd0;
        w_res.cpu_done       = w_done;
        w_res.line_state     = w_ns;
        w_res.protocol_error = w_err;
        if (r_cmd.op == OP_DROP) begin
            w_res = '0;
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_CLEAR: begin
                if (r_clr_idx == '1) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                if (w_out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_CLEAR;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_q_pop    = 1'b0;
        w_mem_re   = 1'b0;
        w_mem_we   = 1'b0;
        w_mem_wa   = r_idx;
        w_mem_wd   = w_ns;
        w_out_load = 1'b0;
        w_clr_step = 1'b0;
        case (r_state)
            BK_CLEAR: begin
                w_mem_we   = 1'b1;
                w_mem_wa   = r_clr_idx;
                w_mem_wd   = ST_I;
                w_clr_step = 1'b1;
            end
            BK_IDLE: begin
                o_q_pop  = i_q_valid;
                w_mem_re = i_q_valid;
            end
            BK_EXEC: begin
                w_out_load = w_out_free;
                w_mem_we   = w_out_free && (r_cmd.op inside {OP_LOOKUP, OP_SNOOP, OP_REPLY});
            end
            default: begin
                w_mem_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_clr_step) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Command capture and result register.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
            r_idx <= i_q_idx;
        end
        if (w_out_load) begin
            r_out_word <= w_res;
        end
    end

    // State store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_wa] <= w_mem_wd;
        end
        if (w_mem_re) begin
            r_rd_data <= r_mem[i_q_idx];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

[tb/scc_checker.sv]
// Checker for the snoop coherence controller: predicts every result word and compares it.
`timescale 1ns / 1ps

module scc_checker
    import scc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_word  i_in_word,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_word i_out_word,
    input  logic      i_cfg_valid,
    input  logic      i_cfg_ready,
    input  logic [2:0] i_cfg_data,
    output int        o_pending,
    output int        o_errors
);

    localparam int LINES = 1 << DEF_LINE_ADDR_BITS;
    localparam int SHOWN_ERRORS = 10;

    // Mirror of the coherence state of every line in every cache.
    t_line      line_tbl [DEF_NUM_CACHES][LINES];
    logic [2:0] proto_sel;
    t_out_word  expected_results [$];

    initial begin
        for (int c = 0; c < DEF_NUM_CACHES; c++) begin
            for (int a = 0; a < LINES; a++) begin
                line_tbl[c][a] = ST_I;
            end
        end
        proto_sel = PROTO_MI;
        o_pending = 0;
        o_errors  = 0;
    end

    // Works out the result of one word and updates the mirrored line state.
    function automatic t_out_word coherence_step(input t_in_word w);
        t_out_word r;
        t_proto    p;
        t_line     s;
        t_line     ns;
        r  = '0;
        p  = (proto_sel > PROTO_MESIF) ? PROTO_MI : t_proto'(proto_sel);
        s  = line_tbl[w.cache_id][w.line_address];
        ns = s;
        case (w.action)
            ACT_LOOKUP: begin
                if (!w.is_store) begin
                    case (p)
                        PROTO_MSI:   r.hit = s inside {ST_M, ST_S};
                        PROTO_MESI:  r.hit = s inside {ST_M, ST_E, ST_S};
                        PROTO_MOESI: r.hit = s inside {ST_M, ST_O, ST_E, ST_S};
                        PROTO_MESIF: r.hit = s inside {ST_M, ST_E, ST_S, ST_F};
                        default:     r.hit = (s == ST_M);
                    endcase
                end else if (s == ST_M) begin
                    r.hit = 1'b1;
                end else if (s == ST_E && p != PROTO_MI && p != PROTO_MSI) begin
                    // A store hit on an exclusive line makes it modified.
                    r.hit = 1'b1;
                    ns    = ST_M;
                end
                if (r.hit) begin
                    r.cpu_done = 1'b1;
                end else if (w.is_store && s == ST_S &&
                             (p == PROTO_MSI || p == PROTO_MESI)) begin
                    r.bus_request = BUS_UPGRADE;
                end else begin
                    r.bus_request = w.is_store ? BUS_WRITE : BUS_READ;
                end
            end
            ACT_SNOOP: begin
                // An invalid line ignores every snoop.
                if (s != ST_I) begin
                    case (w.snoop_kind)
                        SN_READ: begin
                            case (p)
                                PROTO_MSI, PROTO_MESI: begin
                                    ns = ST_S;
                                    r.snoop_answer = ANS_SHARED;
                                end
                                PROTO_MOESI: begin
                                    if (s == ST_S || s == ST_F) begin
                                        ns = ST_S;
                                    end else begin
                                        ns = ST_O;
                                        r.snoop_answer = ANS_SHARED;
                                    end
                                end
                                PROTO_MESIF: begin
                                    ns = ST_S;
                                    if (s != ST_S) r.snoop_answer = ANS_SHARED;
                                end
                                default: begin
                                    ns = ST_I;
                                    if (s == ST_M) r.snoop_answer = ANS_DATA;
                                end
                            endcase
                        end
                        SN_WRITE: begin
                            ns = ST_I;
                            if (p == PROTO_MI) begin
                                r.snoop_answer = (s == ST_M) ? ANS_DATA : ANS_NONE;
                            end else if (p == PROTO_MESIF) begin
                                r.snoop_answer = (s == ST_S) ? ANS_NONE : ANS_DATA;
                            end else begin
                                r.snoop_answer = ANS_DATA;
                            end
                        end
                        SN_UPGRADE: begin
                            // Another cache cannot upgrade while we own the line.
                            if (s == ST_M || s == ST_E) r.protocol_error = 1'b1;
                            else ns = ST_I;
                        end
                        default: ;
                    endcase
                end
            end
            ACT_REPLY: begin
                if (w.reply_kind inside {RP_CACHE, RP_MEMORY, RP_SHARED}) begin
                    if (w.is_store || p == PROTO_MI) ns = ST_M;
                    else if (w.reply_kind == RP_SHARED) ns = (p == PROTO_MESIF) ? ST_F : ST_S;
                    else ns = (p == PROTO_MSI) ? ST_M : ST_E;
                    r.cpu_done = 1'b1;
                end
            end
            default: ;
        endcase
        r.answer_dest = (r.snoop_answer != ANS_NONE) ? w.requester : 2'd0;
        r.line_state  = ns;
        line_tbl[w.cache_id][w.line_address] = ns;
        return r;
    endfunction

    // Watch all three channels at each rising edge.
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) proto_sel = i_cfg_data;
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    if (o_errors < SHOWN_ERRORS)
                        $display("%0t: result word with nothing expected: %h",
                                 $realtime, i_out_word);
                    o_errors++;
                end else begin
                    exp_w = expected_results.pop_front();
                    if (i_out_word.hit !== exp_w.hit ||
                        i_out_word.bus_request !== exp_w.bus_request ||
                        i_out_word.snoop_answer !== exp_w.snoop_answer ||
                        i_out_word.answer_dest !== exp_w.answer_dest ||
                        i_out_word.cpu_done !== exp_w.cpu_done ||
                        i_out_word.line_state !== exp_w.line_state ||
                        i_out_word.protocol_error !== exp_w.protocol_error) begin
                        if (o_errors < SHOWN_ERRORS)
                            $display({"%0t: mismatch hit/bus/ans/dest/done/state/err ",
                                      "expected %0d/%0d/%0d/%0d/%0d/%0d/%0d ",
                                      "got %0d/%0d/%0d/%0d/%0d/%0d/%0d"}, $realtime,
                                     exp_w.hit, exp_w.bus_request, exp_w.snoop_answer,
                                     exp_w.answer_dest, exp_w.cpu_done,
                                     exp_w.line_state, exp_w.protocol_error,
                                     i_out_word.hit, i_out_word.bus_request,
                                     i_out_word.snoop_answer, i_out_word.answer_dest,
                                     i_out_word.cpu_done, i_out_word.line_state,
                                     i_out_word.protocol_error);
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) expected_results.push_back(coherence_step(i_in_word));
            o_pending = expected_results.size();
        end
    end

endmodule

[tb/tb_snoop_coherence_controller_top.sv]
// Testbench top for the snoop coherence controller: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_snoop_coherence_controller_top;
    import scc_pkg::*;

    localparam int STUCK_LIMIT     = 20000;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int HOLD_PHASE      = 4;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOT_COUNT       = 6;
    localparam int SETTLE_CYCLES   = 16;

    // Codes the block must ignore; protocol code 7 is reserved and acts as MI.
    localparam logic [1:0] ACT_RESERVED   = 2'd3;
    localparam logic [1:0] SN_RESERVED    = 2'd3;
    localparam logic [1:0] RP_RESERVED    = 2'd3;
    localparam logic [2:0] PROTO_RESERVED = 3'd7;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    t_in_word   i_in_word = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_word  o_out_word;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_data = '0;

    int pending;
    int errors;
    int stuck_cycles = 0;
    int items_done = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_taken = 1'b0;
    int hold_left = 0;
    logic [9:0] hot_addr [HOT_COUNT];

    logic [2:0] ph_proto [NUM_PHASES] = '{PROTO_MI, PROTO_MSI, PROTO_MESI, PROTO_MOESI,
                                          PROTO_MESIF, PROTO_RESERVED, PROTO_MOESI,
                                          PROTO_MESI};
    int ph_send_idle [NUM_PHASES] = '{0, 77, 0, 26, 0, 77, 0, 26};
    int ph_stall [NUM_PHASES]     = '{0, 0, 77, 26, 0, 0, 77, 26};

    snoop_coherence_controller_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    scc_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Result side: random stalls, plus one long hold-off to back the block up.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_taken) begin
                hold_left  = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else begin
                i_out_ready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Ends the run when no channel has moved a word for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    function automatic t_in_word mk_word(input logic [1:0] act, input logic [1:0] cid,
                                         input logic [9:0] addr, input logic st,
                                         input logic [1:0] sk, input logic [1:0] rk,
                                         input logic [1:0] req);
        t_in_word w;
        w.action       = act;
        w.cache_id     = cid;
        w.line_address = addr;
        w.is_store     = st;
        w.snoop_kind   = sk;
        w.reply_kind   = rk;
        w.requester    = req;
        return w;
    endfunction

    // Mostly a few busy lines so that snoops and lookups find valid states.
    function automatic logic [9:0] pick_addr();
        logic [9:0] a;
        if ($urandom_range(99) < 85) a = hot_addr[$urandom_range(HOT_COUNT - 1)];
        else a = 10'($urandom);
        return a;
    endfunction

    function automatic logic [1:0] rand_snoop();
        logic [1:0] k;
        if ($urandom_range(99) < 4) k = SN_RESERVED;
        else k = 2'($urandom_range(SN_UPGRADE));
        return k;
    endfunction

    function automatic logic [1:0] rand_reply();
        logic [1:0] k;
        if ($urandom_range(99) < 4) k = RP_RESERVED;
        else k = 2'($urandom_range(RP_SHARED));
        return k;
    endfunction

    // Offers one word; valid stays high after acceptance until the next call decides.
    task automatic send_word(input t_in_word w);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_word  = w;
        do @(posedge i_clk); while (!o_in_ready);
        if (w.action != ACT_RESERVED) items_done++;
    endtask

    // Stops offering words until every expected result word has been taken.
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_protocol(input logic [2:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Mostly miss/fill/reuse/snoop sequences on one line, the rest loose words.
    task automatic random_traffic(input int target);
        logic [1:0] cid;
        logic [1:0] act;
        logic [9:0] addr;
        logic       st;
        int         roll;
        items_done = 0;
        while (items_done < target) begin
            cid  = 2'($urandom_range(3));
            addr = pick_addr();
            st   = 1'($urandom_range(1));
            if ($urandom_range(99) < 55) begin
                send_word(mk_word(ACT_LOOKUP, cid, addr, st, rand_snoop(), rand_reply(),
                                  2'($urandom_range(3))));
                send_word(mk_word(ACT_REPLY, cid, addr, st, rand_snoop(), rand_reply(),
                                  2'($urandom_range(3))));
                send_word(mk_word(ACT_LOOKUP, cid, addr, 1'($urandom_range(1)),
                                  rand_snoop(), rand_reply(), 2'($urandom_range(3))));
                send_word(mk_word(ACT_SNOOP, cid, addr, 1'($urandom_range(1)),
                                  rand_snoop(), rand_reply(),
                                  cid + 2'($urandom_range(1, 3))));
            end else begin
                roll = $urandom_range(99);
                if (roll < 38) act = ACT_LOOKUP;
                else if (roll < 68) act = ACT_SNOOP;
                else if (roll < 95) act = ACT_REPLY;
                else act = ACT_RESERVED;
                send_word(mk_word(act, cid, addr, st, rand_snoop(), rand_reply(),
                                  2'($urandom_range(3))));
            end
        end
    endtask

    initial begin
        hot_addr[0] = '0;
        hot_addr[1] = '1;
        for (int h = 2; h < HOT_COUNT; h++) hot_addr[h] = 10'($urandom);

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed walk under MESIF through fills, hits, snoops and ignored codes.
        write_protocol(PROTO_MESIF);
        send_word(mk_word(ACT_LOOKUP, 2'd0, 10'd0, 1'b0, SN_READ, RP_CACHE, 2'd0));
        send_word(mk_word(ACT_REPLY, 2'd0, 10'd0, 1'b0, SN_READ, RP_SHARED, 2'd0));
        send_word(mk_word(ACT_LOOKUP, 2'd0, 10'd0, 1'b0, SN_READ, RP_CACHE, 2'd0));
        send_word(mk_word(ACT_SNOOP, 2'd0, 10'd0, 1'b1, SN_READ, RP_CACHE, 2'd3));
        send_word(mk_word(ACT_SNOOP, 2'd0, 10'd0, 1'b0, SN_UPGRADE, RP_SHARED, 2'd1));
        send_word(mk_word(ACT_LOOKUP, 2'd3, 10'd1023, 1'b1, SN_UPGRADE, RP_SHARED, 2'd3));
        send_word(mk_word(ACT_REPLY, 2'd3, 10'd1023, 1'b1, SN_READ, RP_MEMORY, 2'd0));
        send_word(mk_word(ACT_LOOKUP, 2'd3, 10'd1023, 1'b1, SN_READ, RP_CACHE, 2'd0));
        send_word(mk_word(ACT_SNOOP, 2'd3, 10'd1023, 1'b0, SN_UPGRADE, RP_CACHE, 2'd2));
        send_word(mk_word(ACT_SNOOP, 2'd3, 10'd1023, 1'b0, SN_WRITE, RP_CACHE, 2'd0));
        send_word(mk_word(ACT_REPLY, 2'd2, 10'd512, 1'b0, SN_READ, RP_CACHE, 2'd1));
        send_word(mk_word(ACT_LOOKUP, 2'd2, 10'd512, 1'b1, SN_READ, RP_CACHE, 2'd1));
        send_word(mk_word(ACT_SNOOP, 2'd2, 10'd512, 1'b1, SN_RESERVED, RP_RESERVED, 2'd3));
        send_word(mk_word(ACT_REPLY, 2'd2, 10'd512, 1'b1, SN_RESERVED, RP_RESERVED, 2'd3));
        send_word(mk_word(ACT_RESERVED, 2'd1, 10'd5, 1'b1, SN_WRITE, RP_SHARED, 2'd2));
        send_word(mk_word(ACT_SNOOP, 2'd1, 10'd5, 1'b0, SN_READ, RP_CACHE, 2'd2));

        // Random phases, each under its own protocol and idling pattern.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            send_idle_pct = ph_send_idle[ph];
            stall_pct     = ph_stall[ph];
            write_protocol(ph_proto[ph]);
            hold_req = (ph == HOLD_PHASE);
            random_traffic(ITEMS_PER_PHASE);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
